@@ hw/rtl/frgcd_pkg.sv @@
// ----------------------------------------------------------------------------
// frgcd_pkg
// Shared widths and types for the fraction reducer and its serial divider.
// ----------------------------------------------------------------------------
package frgcd_pkg;

    localparam int W_IN  = 32;           // signed input / output denominator width
    localparam int W_MAG = 31;           // magnitude width after saturation
    localparam int W_CNT = $clog2(W_MAG); // divider step counter width

    // divider status seen by the controller
    typedef struct packed {
        logic busy;
        logic done;
    } t_div_stat;

endpackage

@@ hw/rtl/frgcd_div.sv @@
// ----------------------------------------------------------------------------
// frgcd_div
// Restoring divider, one quotient bit per cycle, gives quotient and remainder.
// ----------------------------------------------------------------------------
module frgcd_div (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  logic [frgcd_pkg::W_MAG-1:0]  i_dividend,
    input  logic [frgcd_pkg::W_MAG-1:0]  i_divisor,
    output frgcd_pkg::t_div_stat         o_stat,
    output logic [frgcd_pkg::W_MAG-1:0]  o_quot,
    output logic [frgcd_pkg::W_MAG-1:0]  o_rem
);
    import frgcd_pkg::*;

    logic             r_busy;
    logic             r_done;
    logic [W_CNT-1:0] r_cnt;
    logic [W_MAG-1:0] r_rem;
    logic [W_MAG-1:0] r_quo;
    logic [W_MAG-1:0] r_div;

    logic [W_MAG:0]   partial;
    logic [W_MAG+1:0] diff;
    logic             fits;

    // shift the next dividend bit into the partial remainder and trial subtract
    assign partial = {r_rem, r_quo[W_MAG-1]};
    assign diff    = {1'b0, partial} - {2'b00, r_div};
    assign fits    = ~diff[W_MAG+1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (!r_busy) begin
                if (i_start) begin
                    r_busy <= 1'b1;
                    r_cnt  <= W_CNT'(W_MAG - 1);
                end
            end else begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_busy && i_start) begin
            r_rem <= '0;
            r_quo <= i_dividend;
            r_div <= i_divisor;
        end else if (r_busy) begin
            r_rem <= fits ? diff[W_MAG-1:0] : partial[W_MAG-1:0];
            r_quo <= {r_quo[W_MAG-2:0], fits};
        end
    end

    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;
    assign o_quot      = r_quo;
    assign o_rem       = r_rem;

    a_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start |-> !r_busy)
        else $error("divider started while busy");
    a_done_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> $past(r_busy))
        else $error("divider done without running");
    a_rem_below_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> (r_rem < r_div))
        else $error("remainder not below divisor");

endmodule

@@ hw/rtl/fraction_reduce_gcd.sv @@
// ----------------------------------------------------------------------------
// fraction_reduce_gcd
// Reduces a signed fraction to lowest terms by Euclid's remainder loop.
// ----------------------------------------------------------------------------
// a zero numerator is answered in the cycle after it is accepted; otherwise the result
//   follows k Euclid remainder steps (at most 45), each a pass through the shared
//   bit-serial divider, and then the two final divisions
// throughput: one beat at a time, next start accepted the cycle o_valid rises
// reset: synchronous active low, returns to idle, pending work is dropped
// the result strobe lasts one cycle and cannot be held off
module fraction_reduce_gcd (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic signed [frgcd_pkg::W_IN-1:0] i_numer_in,
    input  logic signed [frgcd_pkg::W_IN-1:0] i_denom_in,
    output logic                              o_valid,
    output logic        [frgcd_pkg::W_MAG-1:0] o_numer_out,
    output logic signed [frgcd_pkg::W_IN-1:0] o_denom_out
);
    import frgcd_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_GCD,
        S_GCD_WAIT,
        S_QN_WAIT,
        S_QD_WAIT
    } t_state;

    t_state           r_state;
    logic             r_valid;
    logic [W_MAG-1:0] r_numer_out;
    logic [W_IN-1:0]  r_denom_out;
    logic [W_MAG-1:0] r_n_mag;
    logic [W_MAG-1:0] r_d_mag;
    logic             r_d_neg;
    logic [W_MAG-1:0] r_a;
    logic [W_MAG-1:0] r_b;
    logic [W_MAG-1:0] r_g;
    logic [W_MAG-1:0] r_qn;

    logic [W_IN-1:0]  sat_n;
    logic [W_IN-1:0]  sat_d;
    logic [W_IN-1:0]  abs_n;
    logic [W_IN-1:0]  abs_d;
    logic             n_neg;
    logic             d_neg;
    logic [W_IN-1:0]  neg_qd;

    logic             div_start;
    logic [W_MAG-1:0] div_dividend;
    logic [W_MAG-1:0] div_divisor;
    t_div_stat        div_stat;
    logic [W_MAG-1:0] div_quot;
    logic [W_MAG-1:0] div_rem;

    // most negative value saturates one step up
    assign sat_n = (i_numer_in == {1'b1, {(W_IN-1){1'b0}}}) ?
                   {1'b1, {(W_IN-2){1'b0}}, 1'b1} : i_numer_in;
    assign sat_d = (i_denom_in == {1'b1, {(W_IN-1){1'b0}}}) ?
                   {1'b1, {(W_IN-2){1'b0}}, 1'b1} : i_denom_in;
    assign n_neg = sat_n[W_IN-1];
    assign abs_n = n_neg ? (~sat_n + 1'b1) : sat_n;
    assign abs_d = sat_d[W_IN-1] ? (~sat_d + 1'b1) : sat_d;
    // sign flip of the numerator moves onto the denominator
    assign d_neg = (sat_d != '0) && (sat_d[W_IN-1] ^ n_neg);
    assign neg_qd = ~{1'b0, div_quot} + 1'b1;

    always_comb begin
        div_start    = 1'b0;
        div_dividend = r_a;
        div_divisor  = r_b;
        unique case (r_state)
            S_GCD: begin
                if (r_b == '0) begin
                    div_start    = 1'b1;
                    div_dividend = r_n_mag;
                    div_divisor  = r_a;
                end else begin
                    div_start = 1'b1;
                end
            end
            S_QN_WAIT: begin
                div_start    = div_stat.done;
                div_dividend = r_d_mag;
                div_divisor  = r_g;
            end
            default: begin
                div_start = 1'b0;
            end
        endcase
    end

    frgcd_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_dividend),
        .i_divisor  (div_divisor),
        .o_stat     (div_stat),
        .o_quot     (div_quot),
        .o_rem      (div_rem)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_valid <= 1'b0;
        end else begin
            r_valid <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (start) begin
                        r_n_mag <= abs_n[W_MAG-1:0];
                        r_d_mag <= abs_d[W_MAG-1:0];
                        r_d_neg <= d_neg;
                        r_a     <= abs_n[W_MAG-1:0];
                        r_b     <= abs_d[W_MAG-1:0];
                        if (sat_n == '0) begin
                            // zero numerator always reads 0/1
                            r_valid     <= 1'b1;
                            r_numer_out <= '0;
                            r_denom_out <= W_IN'(1);
                        end else begin
                            r_state <= S_GCD;
                        end
                    end
                end
                S_GCD: begin
                    if (r_b == '0) begin
                        r_g     <= r_a;
                        r_state <= S_QN_WAIT;
                    end else begin
                        r_state <= S_GCD_WAIT;
                    end
                end
                S_GCD_WAIT: begin
                    if (div_stat.done) begin
                        r_a     <= r_b;
                        r_b     <= div_rem;
                        r_state <= S_GCD;
                    end
                end
                S_QN_WAIT: begin
                    if (div_stat.done) begin
                        r_qn    <= div_quot;
                        r_state <= S_QD_WAIT;
                    end
                end
                S_QD_WAIT: begin
                    if (div_stat.done) begin
                        r_valid     <= 1'b1;
                        r_numer_out <= r_qn;
                        r_denom_out <= r_d_neg ? neg_qd : {1'b0, div_quot};
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign busy        = (r_state != S_IDLE);
    assign o_valid     = r_valid;
    assign o_numer_out = r_numer_out;
    assign o_denom_out = r_denom_out;

    a_valid_after_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !busy)
        else $error("result beat while still busy");
    a_zero_numer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_numer_out == '0) |-> (o_denom_out == W_IN'(1)))
        else $error("zero numerator not reported as 0/1");
    a_gcd_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_QN_WAIT) |-> (r_g != '0))
        else $error("zero divisor used for reduction");
    a_wait_div_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_GCD_WAIT && !div_stat.done) |-> div_stat.busy)
        else $error("waiting on an idle divider");

endmodule
